### hdl/sum_checked_frame_receiver_core_assert.svh
// Assertion macros used by the port-level checker of the frame receiver.
// No dependencies; include by bare file name.
`ifndef SUM_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SCFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SCFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scfr: next-cycle check failed");

`endif

### hdl/scfr_pkg.sv
// Package for the sum-checked frame receiver: frame bytes, parser phase
// type and the parser result struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hA5;
    localparam logic [7:0] TRAILER_BYTE = 8'h5A;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CHECK   = 2'd2,
        PH_TRAIL   = 2'd3
    } t_phase;

    typedef struct packed {
        logic               emit;
        logic signed [15:0] channel_zero;
        logic signed [15:0] channel_one;
    } t_parse_res;

endpackage

`default_nettype wire

### hdl/scfr_parser.sv
// Frame parser: phase state machine, payload counter, running sum and
// the first four payload bytes. Depends on scfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scfr_parser
    import scfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_parse_res      o_res
);

    localparam int CNT_W = $clog2(PAYLOAD_LEN + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_LEN);
    localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(4);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_head [4];
    logic             head_wr;
    logic [CNT_W-1:0] count_inc;

    assign count_inc = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Head bytes carry no reset: every entry is written before a trailer is seen.
    always_ff @(posedge i_clk) begin
        if (i_step && head_wr) begin
            r_head[r_count[1:0]] <= i_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        head_wr = 1'b0;
        o_res.emit         = 1'b0;
        o_res.channel_zero = {r_head[1], r_head[0]};
        o_res.channel_one  = {r_head[3], r_head[2]};
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == HEADER_BYTE) begin
                    n_phase = PH_PAYLOAD;
                    n_count = '0;
                    n_sum   = '0;
                end
            end
            PH_PAYLOAD: begin
                head_wr = (r_count < HEAD_CNT);
                n_sum   = r_sum + i_byte;
                n_count = count_inc;
                if (count_inc >= LAST_CNT) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = (i_byte == r_sum) ? PH_TRAIL : PH_HUNT;
            end
            PH_TRAIL: begin
                o_res.emit = (i_byte == TRAILER_BYTE);
                n_phase    = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/sum_checked_frame_receiver_core.sv
// A byte taken from the link is held in the input register and then steps the parser; a result
// is loaded into the output register when the trailer byte advances. Throughput: one byte per
// cycle while the link is not stalled, as the parser state (phase, count, running sum) updates
// on every advancing byte; the link stalls only while a closing trailer waits behind a stalled
// frame. Reset is synchronous and active low; it clears the parser state and both valid flags.
// Stored payload bytes are not reset. Depends on scfr_pkg and scfr_parser.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_receiver_core
    import scfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // received byte channel
    input  wire logic               i_rx_valid,
    output logic                    o_rx_stall,
    input  wire logic [7:0]         i_rx_byte,
    // decoded frame channel
    output logic                    o_res_valid,
    input  wire logic               i_res_stall,
    output logic signed [15:0]      o_channel_zero,
    output logic signed [15:0]      o_channel_one
);

    // Input register: holds one byte between the link and the parser.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Output register: holds a decoded frame until the sink takes it.
    logic               r_out_valid;
    logic signed [15:0] r_out_ch0;
    logic signed [15:0] r_out_ch1;

    t_parse_res parse_res;
    logic       out_free;
    logic       advance;
    logic       rx_take;

    // The output register is free when empty or being read in this cycle.
    assign out_free = !r_out_valid || !i_res_stall;

    // Advance the held byte into the parser; a byte that closes a frame needs
    // room in the output register, any other byte goes straight through.
    assign advance  = r_in_valid && (out_free || !parse_res.emit);

    // Stall the link only while a byte is held and cannot advance.
    assign o_rx_stall = r_in_valid && !advance;
    assign rx_take    = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scfr_parser #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (parse_res)
    );

    // Load a finished frame, otherwise drop the valid once the sink has it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && parse_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_res.emit) begin
            r_out_ch0 <= parse_res.channel_zero;
            r_out_ch1 <= parse_res.channel_one;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_channel_zero = r_out_ch0;
    assign o_channel_one  = r_out_ch1;

endmodule

`default_nettype wire

### hdl/scfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
// Depends on sum_checked_frame_receiver_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_frame_receiver_core_assert.svh"

module scfr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_rx_stall,
    input  wire logic        o_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic [15:0] o_channel_zero,
    input  wire logic [15:0] o_channel_one
);

    // A stalled frame holds.
    `SCFR_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_res_valid && i_res_stall,
        o_res_valid && $stable(o_channel_zero) && $stable(o_channel_one))

    // The link is stalled only behind a blocked frame.
    `SCFR_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_rx_stall, o_res_valid && i_res_stall)

    // With the output empty the receiver always takes a byte.
    `SCFR_ASSERT_IMP(a_no_stall_empty, i_clk, i_rst_n, !o_res_valid, !o_rx_stall)

    // A new frame is loaded only in a cycle where the held byte advanced.
    `SCFR_ASSERT_IMP(a_load_advance, i_clk, i_rst_n, $rose(o_res_valid), !$past(o_rx_stall))

endmodule

bind sum_checked_frame_receiver_core scfr_checker u_scfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_stall     (o_rx_stall),
    .o_res_valid    (o_res_valid),
    .i_res_stall    (i_res_stall),
    .o_channel_zero (o_channel_zero),
    .o_channel_one  (o_channel_one)
);

`default_nettype wire

### bench/scfr_frame_checker.sv
// Frame checker for the sum-checked frame receiver: watches both channels, predicts
// the decoded frames from the accepted bytes and compares them. Depends on scfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scfr_frame_checker
    import scfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rx_valid,
    input  wire logic               i_rx_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_stall,
    input  wire logic signed [15:0] i_channel_zero,
    input  wire logic signed [15:0] i_channel_one,
    output int                      o_fail_count,
    output int                      o_frames_due
);

    typedef struct packed {
        logic signed [15:0] channel_zero;
        logic signed [15:0] channel_one;
    } t_frame_words;

    t_frame_words frames_due[$];

    t_phase     parse_phase;
    logic [7:0] payload_count;
    logic [7:0] payload_sum;
    logic [7:0] frame_head [4];
    int         mismatches;

    initial begin
        o_fail_count = 0;
        o_frames_due = 0;
        mismatches   = 0;
    end

    // Step the parser by one accepted byte; queue the frame on a good trailer.
    task automatic parse_byte(input logic [7:0] rx);
        t_frame_words words;
        case (parse_phase)
            PH_HUNT: begin
                if (rx == HEADER_BYTE) begin
                    parse_phase   = PH_PAYLOAD;
                    payload_count = 8'd0;
                    payload_sum   = 8'd0;
                end
            end
            PH_PAYLOAD: begin
                if (payload_count < 8'd4)
                    frame_head[payload_count[1:0]] = rx;
                payload_sum   = payload_sum + rx;
                payload_count = payload_count + 8'd1;
                if (int'(payload_count) >= PAYLOAD_LEN)
                    parse_phase = PH_CHECK;
            end
            PH_CHECK: begin
                parse_phase = (rx == payload_sum) ? PH_TRAIL : PH_HUNT;
            end
            default: begin
                if (rx == TRAILER_BYTE) begin
                    words.channel_zero = {frame_head[1], frame_head[0]};
                    words.channel_one  = {frame_head[3], frame_head[2]};
                    frames_due.push_back(words);
                end
                parse_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic check_frame();
        t_frame_words want;
        if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected frame: ch0=%0d ch1=%0d", i_channel_zero, i_channel_one);
        end else begin
            want = frames_due.pop_front();
            if (i_channel_zero !== want.channel_zero || i_channel_one !== want.channel_one) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame mismatch: expected ch0=%0d ch1=%0d, got ch0=%0d ch1=%0d",
                             want.channel_zero, want.channel_one,
                             i_channel_zero, i_channel_one);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase   = PH_HUNT;
            payload_count = 8'd0;
            payload_sum   = 8'd0;
            frame_head    = '{default: 8'd0};
        end else begin
            if (i_res_valid && !i_res_stall)
                check_frame();
            if (i_rx_valid && !i_rx_stall)
                parse_byte(i_rx_byte);
        end
        o_fail_count <= mismatches;
        o_frames_due <= frames_due.size();
    end

endmodule

`default_nettype wire

### bench/tb_sum_checked_frame_receiver_core.sv
// Testbench top for sum_checked_frame_receiver_core: drives bytes in bursts, stalls the
// frame channel and gives the verdict. Depends on scfr_pkg and scfr_frame_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_sum_checked_frame_receiver_core
    import scfr_pkg::*;
();

    localparam int FRAME_LEN    = 4;
    localparam int RANDOM_BYTES = 700;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 10;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               rx_valid  = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte   = 8'd0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [15:0] channel_zero;
    logic signed [15:0] channel_one;

    int fail_count;
    int frames_due;

    logic rx_accept;
    logic res_accept;
    assign rx_accept  = rx_valid && !rx_stall;
    assign res_accept = res_valid && !res_stall;

    // Sender burst state, receiver stall state and watchdog count.
    int burst_left  = 0;
    int bytes_sent  = 0;
    int stall_run   = 0;
    int stall_pick;
    int idle_cycles = 0;

    // Directed opening: extremes of both channels, header and trailer bytes inside a
    // payload, a bad trailer that is itself a header byte (the following bytes would
    // only make a frame if it were rechecked), and a bad checksum equal to the header.
    logic [7:0] opening_bytes [26] = '{
        8'hA5, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFE, 8'h5A,
        8'hA5, 8'hA5, 8'hA5, 8'h5A, 8'hA5, 8'h49, 8'hA5,
        8'h01, 8'h02, 8'h03, 8'h04, 8'h0A, 8'h5A,
        8'hA5, 8'h01, 8'h02, 8'h03, 8'h04, 8'hA5
    };

    initial begin
        forever #5 clk = ~clk;
    end

    sum_checked_frame_receiver_core #(
        .PAYLOAD_LEN    (FRAME_LEN)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_channel_zero (channel_zero),
        .o_channel_one  (channel_one)
    );

    scfr_frame_checker #(
        .PAYLOAD_LEN    (FRAME_LEN)
    ) frame_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_channel_zero (channel_zero),
        .i_channel_one  (channel_one),
        .o_fail_count   (fail_count),
        .o_frames_due   (frames_due)
    );

    // Receiver: alternate short stall runs, short open runs and long calm stretches
    // with no stall at all, so back-pressure lands on every parser phase.
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_pick = $urandom_range(0, 3);
            case (stall_pick)
                0: begin
                    res_stall <= 1'b1;
                    stall_run <= $urandom_range(0, 5);
                end
                1: begin
                    res_stall <= 1'b0;
                    stall_run <= $urandom_range(20, 60);
                end
                default: begin
                    res_stall <= 1'b0;
                    stall_run <= $urandom_range(0, 3);
                end
            endcase
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // Watchdog: end the run if neither channel moves a transaction for too long.
    always @(posedge clk) begin
        if (rx_accept || res_accept) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Mostly uniform bytes, with the corner values and the frame bytes mixed in.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corner [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, HEADER_BYTE, TRAILER_BYTE};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte and hold it until the block takes the transaction. At the end
    // of a burst, drop valid for a random gap first; a zero gap keeps valid high.
    task automatic push_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Send header, four payload bytes, checksum (optionally corrupted) and trailer.
    task automatic push_frame(input logic [7:0] csum_flip, input logic [7:0] trailer);
        logic [7:0] payload [4];
        logic [7:0] csum;
        csum = 8'd0;
        foreach (payload[k]) begin
            payload[k] = pick_byte();
            csum       = csum + payload[k];
        end
        push_byte(HEADER_BYTE);
        foreach (payload[k])
            push_byte(payload[k]);
        push_byte(csum ^ csum_flip);
        push_byte(trailer);
    endtask

    initial begin
        int         kind;
        int         count;
        logic [7:0] bad_trailer;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[k])
            push_byte(opening_bytes[k]);

        // Random part: mostly good frames, the rest corrupted frames, cut-off frames
        // and loose noise bytes.
        while (bytes_sent < 26 + RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            case (kind)
                6: push_frame(8'($urandom_range(1, 255)), TRAILER_BYTE);
                7: begin
                    bad_trailer = pick_byte();
                    if (bad_trailer == TRAILER_BYTE)
                        bad_trailer = HEADER_BYTE;
                    push_frame(8'd0, bad_trailer);
                end
                8: begin
                    count = $urandom_range(1, 6);
                    repeat (count) push_byte(pick_byte());
                end
                9: begin
                    push_byte(HEADER_BYTE);
                    count = $urandom_range(1, 3);
                    repeat (count) push_byte(pick_byte());
                end
                default: push_frame(8'd0, TRAILER_BYTE);
            endcase
        end
        rx_valid <= 1'b0;

        // Drain: wait for every predicted frame, then wait TAIL_CYCLES longer for strays.
        while (frames_due != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
